FILE: rtl/core/sphere_obb_overlap_test_core_macros.svh
// ----------------------------------------------------------------------------
// Sphere/OBB overlap core assertion macros
// Shared concurrent assertion wrappers, clocked on rising edge with
// active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SPHERE_OBB_OVERLAP_TEST_CORE_MACROS_SVH
`define SPHERE_OBB_OVERLAP_TEST_CORE_MACROS_SVH

// same-cycle implication
`define SOBB_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sobb assertion failed");

// next-cycle implication
`define SOBB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sobb assertion failed");

`endif

FILE: rtl/core/sobb_pkg.sv
// ----------------------------------------------------------------------------
// Sphere/OBB overlap package
// Shared widths, register map codes, config struct and lane and axis helpers.
// ----------------------------------------------------------------------------
package sobb_pkg;

    localparam int AXIS_COUNT  = 3;
    localparam int LANE_BITS   = 16;
    localparam int REG_BITS    = 48;
    localparam int AXIS_FRAC   = 14;
    localparam int RADIUS_BITS = 15;
    localparam int DSQ_BITS    = 36;
    localparam int MAG_BITS    = 18;   // |diff| below 2^18 squares into 36 bits
    localparam int T_BITS      = LANE_BITS + 1;
    localparam int ADDR_BITS   = 6;
    localparam int DATA_BITS   = 64;

    localparam logic [DSQ_BITS-1:0] DSQ_MAX = '1;

    // register indexes, byte address = 8 * index
    localparam logic [2:0] REG_BOX_CENTER  = 3'd0;
    localparam logic [2:0] REG_HALF_EXTENT = 3'd1;
    localparam logic [2:0] REG_AXIS_FIRST  = 3'd2;
    localparam logic [2:0] REG_AXIS_SECOND = 3'd3;
    localparam logic [2:0] REG_AXIS_THIRD  = 3'd4;

    typedef struct packed {
        logic [REG_BITS-1:0] box_center;
        logic [REG_BITS-1:0] half_extent;
        logic [REG_BITS-1:0] axis_first;
        logic [REG_BITS-1:0] axis_second;
        logic [REG_BITS-1:0] axis_third;
    } cfg_t;

    function automatic logic [LANE_BITS-1:0] lane(input logic [REG_BITS-1:0] r,
                                                  input logic [1:0] k);
        lane = r[k*LANE_BITS +: LANE_BITS];
    endfunction

    function automatic logic [REG_BITS-1:0] axis_of(input cfg_t cfg, input logic [1:0] i);
        case (i)
            2'd0:    axis_of = cfg.axis_first;
            2'd1:    axis_of = cfg.axis_second;
            default: axis_of = cfg.axis_third;
        endcase
    endfunction

endpackage

FILE: rtl/core/sphere_obb_overlap_test_core.sv
// ----------------------------------------------------------------------------
// Sphere versus oriented box overlap core
// Tests each incoming sphere against a configured oriented box and returns
// the closest box point, the squared distance and a hit flag.
// ----------------------------------------------------------------------------
// One sphere enters per clock while s_ready is high and moves through
// three projection stages (offset, axis products, clamp), two closest-point
// stages (axis steps, accumulate) and three distance stages (difference,
// squares, sum and compare, the last being the output register). Each stage
// holds its own valid bit, so backpressure on m_ready fills empty stages
// before s_ready drops; a full stalled pipeline holds eight items. Box
// registers sit at byte address 8*index on the APB port and should only be
// written with no sphere in flight.
module sphere_obb_overlap_test_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sobb_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [sobb_pkg::DATA_BITS-1:0]      pwdata,
    output logic [sobb_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    // sphere in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_center_x,
    input  logic signed [COORD_BITS-1:0]        s_center_y,
    input  logic signed [COORD_BITS-1:0]        s_center_z,
    input  logic [sobb_pkg::RADIUS_BITS-1:0]    s_radius,
    // result out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic signed [COORD_BITS-1:0]        m_near_x,
    output logic signed [COORD_BITS-1:0]        m_near_y,
    output logic signed [COORD_BITS-1:0]        m_near_z,
    output logic [sobb_pkg::DSQ_BITS-1:0]       m_distance_sq
);

    localparam int N  = sobb_pkg::AXIS_COUNT;
    localparam int NW = sobb_pkg::LANE_BITS + sobb_pkg::T_BITS + 2 - sobb_pkg::AXIS_FRAC;

    sobb_pkg::cfg_t                       cfg;
    logic signed [COORD_BITS-1:0]         p_in [N];
    logic                                 pj_valid, pj_ready;
    logic signed [COORD_BITS-1:0]         pj_p [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     pj_r;
    logic signed [sobb_pkg::T_BITS-1:0]   pj_t [N];
    logic                                 cl_valid, cl_ready;
    logic signed [COORD_BITS-1:0]         cl_p [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     cl_r;
    logic signed [NW-1:0]                 cl_near [N];
    logic signed [COORD_BITS-1:0]         near_out [N];

    assign p_in[0] = s_center_x;
    assign p_in[1] = s_center_y;
    assign p_in[2] = s_center_z;

    sobb_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sobb_project #(.COORD_BITS(COORD_BITS)) u_project (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_p       (p_in),
        .in_radius  (s_radius),
        .out_valid  (pj_valid),
        .out_ready  (pj_ready),
        .out_p      (pj_p),
        .out_radius (pj_r),
        .out_t      (pj_t)
    );

    sobb_closest #(.COORD_BITS(COORD_BITS)) u_closest (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (pj_valid),
        .in_ready   (pj_ready),
        .in_p       (pj_p),
        .in_radius  (pj_r),
        .in_t       (pj_t),
        .out_valid  (cl_valid),
        .out_ready  (cl_ready),
        .out_p      (cl_p),
        .out_radius (cl_r),
        .out_near   (cl_near)
    );

    sobb_distance #(.COORD_BITS(COORD_BITS)) u_distance (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cl_valid),
        .in_ready  (cl_ready),
        .in_p      (cl_p),
        .in_radius (cl_r),
        .in_near   (cl_near),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_hit   (m_hit),
        .out_near  (near_out),
        .out_dsq   (m_distance_sq)
    );

    assign m_near_x = near_out[0];
    assign m_near_y = near_out[1];
    assign m_near_z = near_out[2];

endmodule

FILE: rtl/core/sobb_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sphere/OBB configuration registers
// APB-style register file holding box center, half extents and axes.
// ----------------------------------------------------------------------------
module sobb_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sobb_pkg::ADDR_BITS-1:0] paddr,
    input  logic [sobb_pkg::DATA_BITS-1:0] pwdata,
    output logic [sobb_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output sobb_pkg::cfg_t                 cfg
);

    sobb_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[sobb_pkg::ADDR_BITS-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                sobb_pkg::REG_BOX_CENTER:  cfg_reg.box_center  <= pwdata[sobb_pkg::REG_BITS-1:0];
                sobb_pkg::REG_HALF_EXTENT: cfg_reg.half_extent <= pwdata[sobb_pkg::REG_BITS-1:0];
                sobb_pkg::REG_AXIS_FIRST:  cfg_reg.axis_first  <= pwdata[sobb_pkg::REG_BITS-1:0];
                sobb_pkg::REG_AXIS_SECOND: cfg_reg.axis_second <= pwdata[sobb_pkg::REG_BITS-1:0];
                sobb_pkg::REG_AXIS_THIRD:  cfg_reg.axis_third  <= pwdata[sobb_pkg::REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            sobb_pkg::REG_BOX_CENTER:  prdata = 64'(cfg_reg.box_center);
            sobb_pkg::REG_HALF_EXTENT: prdata = 64'(cfg_reg.half_extent);
            sobb_pkg::REG_AXIS_FIRST:  prdata = 64'(cfg_reg.axis_first);
            sobb_pkg::REG_AXIS_SECOND: prdata = 64'(cfg_reg.axis_second);
            sobb_pkg::REG_AXIS_THIRD:  prdata = 64'(cfg_reg.axis_third);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/sobb_project.sv
// ----------------------------------------------------------------------------
// Sphere/OBB projection stages
// Offset, per-axis dot products, floor shift and clamp to half extent.
// Three register stages.
// ----------------------------------------------------------------------------
module sobb_project #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sobb_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          in_p [sobb_pkg::AXIS_COUNT],
    input  logic [sobb_pkg::RADIUS_BITS-1:0]      in_radius,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          out_p [sobb_pkg::AXIS_COUNT],
    output logic [sobb_pkg::RADIUS_BITS-1:0]      out_radius,
    output logic signed [sobb_pkg::T_BITS-1:0]    out_t [sobb_pkg::AXIS_COUNT]
);

    localparam int N  = sobb_pkg::AXIS_COUNT;
    localparam int LB = sobb_pkg::LANE_BITS;
    localparam int DW = ((COORD_BITS > LB) ? COORD_BITS : LB) + 1;
    localparam int PW = DW + LB;
    localparam int SW = PW + 2;
    localparam int TW = sobb_pkg::T_BITS;

    // stage A: offset
    logic                                 va_reg;
    logic signed [DW-1:0]                 diff_a_reg [N];
    logic signed [DW-1:0]                 diff_a_next [N];
    logic signed [COORD_BITS-1:0]         p_a_reg [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     r_a_reg;
    // stage B: products offset * axis
    logic                                 vb_reg;
    logic signed [PW-1:0]                 prod_b_reg [N][N];
    logic signed [PW-1:0]                 prod_b_next [N][N];
    logic signed [COORD_BITS-1:0]         p_b_reg [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     r_b_reg;
    // stage C: dot, floor, clamp
    logic                                 vc_reg;
    logic signed [TW-1:0]                 t_c_reg [N];
    logic signed [TW-1:0]                 t_c_next [N];
    logic signed [SW-1:0]                 dot_sh [N];
    logic signed [SW-1:0]                 h_s [N];
    logic signed [COORD_BITS-1:0]         p_c_reg [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     r_c_reg;

    logic en_a, en_b, en_c;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            diff_a_next[k] = DW'(in_p[k])
                - DW'($signed(sobb_pkg::lane(cfg.box_center, 2'(k))));
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int k = 0; k < N; k++) begin
                prod_b_next[i][k] = PW'(diff_a_reg[k])
                    * PW'($signed(sobb_pkg::lane(sobb_pkg::axis_of(cfg, 2'(i)), 2'(k))));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            dot_sh[i] = (SW'(prod_b_reg[i][0]) + SW'(prod_b_reg[i][1])
                         + SW'(prod_b_reg[i][2])) >>> sobb_pkg::AXIS_FRAC;
            h_s[i] = SW'($signed({1'b0, sobb_pkg::lane(cfg.half_extent, 2'(i))}));
            if (dot_sh[i] > h_s[i]) begin
                t_c_next[i] = TW'(h_s[i]);
            end else if (dot_sh[i] < -h_s[i]) begin
                t_c_next[i] = TW'(-h_s[i]);
            end else begin
                t_c_next[i] = TW'(dot_sh[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            diff_a_reg <= diff_a_next;
            p_a_reg    <= in_p;
            r_a_reg    <= in_radius;
        end
        if (en_b) begin
            prod_b_reg <= prod_b_next;
            p_b_reg    <= p_a_reg;
            r_b_reg    <= r_a_reg;
        end
        if (en_c) begin
            t_c_reg <= t_c_next;
            p_c_reg <= p_b_reg;
            r_c_reg <= r_b_reg;
        end
    end

    assign out_valid  = vc_reg;
    assign out_p      = p_c_reg;
    assign out_radius = r_c_reg;
    assign out_t      = t_c_reg;

endmodule

FILE: rtl/core/sobb_closest.sv
// ----------------------------------------------------------------------------
// Sphere/OBB closest point stages
// Axis steps scaled by clamped projections, summed onto the box center.
// Two register stages.
// ----------------------------------------------------------------------------
module sobb_closest #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sobb_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          in_p [sobb_pkg::AXIS_COUNT],
    input  logic [sobb_pkg::RADIUS_BITS-1:0]      in_radius,
    input  logic signed [sobb_pkg::T_BITS-1:0]    in_t [sobb_pkg::AXIS_COUNT],
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS-1:0]          out_p [sobb_pkg::AXIS_COUNT],
    output logic [sobb_pkg::RADIUS_BITS-1:0]      out_radius,
    output logic signed [sobb_pkg::LANE_BITS+sobb_pkg::T_BITS-13:0]
                                                  out_near [sobb_pkg::AXIS_COUNT]
);

    localparam int N  = sobb_pkg::AXIS_COUNT;
    localparam int LB = sobb_pkg::LANE_BITS;
    localparam int MW = LB + sobb_pkg::T_BITS;
    localparam int AW = MW + 2;
    localparam int NW = AW - sobb_pkg::AXIS_FRAC;

    // stage D: axis * t
    logic                                 vd_reg;
    logic signed [MW-1:0]                 m_d_reg [N][N];
    logic signed [MW-1:0]                 m_d_next [N][N];
    logic signed [COORD_BITS-1:0]         p_d_reg [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     r_d_reg;
    // stage E: accumulate and floor shift
    logic                                 ve_reg;
    logic signed [NW-1:0]                 near_e_reg [N];
    logic signed [NW-1:0]                 near_e_next [N];
    logic signed [AW-1:0]                 acc [N];
    logic signed [COORD_BITS-1:0]         p_e_reg [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     r_e_reg;

    logic en_d, en_e;

    assign en_e     = !ve_reg || out_ready;
    assign en_d     = !vd_reg || en_e;
    assign in_ready = en_d;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int k = 0; k < N; k++) begin
                m_d_next[i][k] = MW'($signed(sobb_pkg::lane(sobb_pkg::axis_of(cfg, 2'(i)),
                                                            2'(k))))
                    * MW'(in_t[i]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            acc[k] = (AW'($signed(sobb_pkg::lane(cfg.box_center, 2'(k))))
                      <<< sobb_pkg::AXIS_FRAC)
                   + AW'(m_d_reg[0][k]) + AW'(m_d_reg[1][k]) + AW'(m_d_reg[2][k]);
            near_e_next[k] = NW'(acc[k] >>> sobb_pkg::AXIS_FRAC);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (en_d) vd_reg <= in_valid;
            if (en_e) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            m_d_reg <= m_d_next;
            p_d_reg <= in_p;
            r_d_reg <= in_radius;
        end
        if (en_e) begin
            near_e_reg <= near_e_next;
            p_e_reg    <= p_d_reg;
            r_e_reg    <= r_d_reg;
        end
    end

    assign out_valid  = ve_reg;
    assign out_p      = p_e_reg;
    assign out_radius = r_e_reg;
    assign out_near   = near_e_reg;

endmodule

FILE: rtl/core/sobb_distance.sv
// ----------------------------------------------------------------------------
// Sphere/OBB distance stages
// Coordinate differences, squares, saturating sum, hit compare and
// output saturation. Three register stages, the last is the output register.
// ----------------------------------------------------------------------------
module sobb_distance #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          in_p [sobb_pkg::AXIS_COUNT],
    input  logic [sobb_pkg::RADIUS_BITS-1:0]      in_radius,
    input  logic signed [sobb_pkg::LANE_BITS+sobb_pkg::T_BITS-13:0]
                                                  in_near [sobb_pkg::AXIS_COUNT],
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_hit,
    output logic signed [COORD_BITS-1:0]          out_near [sobb_pkg::AXIS_COUNT],
    output logic [sobb_pkg::DSQ_BITS-1:0]         out_dsq
);

    localparam int N   = sobb_pkg::AXIS_COUNT;
    localparam int NW  = sobb_pkg::LANE_BITS + sobb_pkg::T_BITS + 2 - sobb_pkg::AXIS_FRAC;
    localparam int XW  = (COORD_BITS > NW) ? COORD_BITS : NW;
    localparam int EW  = XW + 1;
    localparam int MB  = sobb_pkg::MAG_BITS;
    localparam int QW  = sobb_pkg::DSQ_BITS;
    localparam int SUW = QW + 2;
    localparam int RW  = 2 * sobb_pkg::RADIUS_BITS;

    localparam logic signed [XW-1:0] SAT_HI = {{(XW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{(XW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    // stage F: |p - near|
    logic                                 vf_reg;
    logic [MB-1:0]                        mag_f_reg [N];
    logic [MB-1:0]                        mag_f_next [N];
    logic                                 big_f_reg;
    logic                                 big_f_next;
    logic signed [EW-1:0]                 d_f [N];
    logic [EW-1:0]                        mag_f [N];
    logic signed [NW-1:0]                 near_f_reg [N];
    logic [sobb_pkg::RADIUS_BITS-1:0]     r_f_reg;
    // stage G: squares
    logic                                 vg_reg;
    logic [QW-1:0]                        sq_g_reg [N];
    logic [QW-1:0]                        sq_g_next [N];
    logic [RW-1:0]                        rsq_g_reg;
    logic                                 big_g_reg;
    logic signed [NW-1:0]                 near_g_reg [N];
    // stage H: sum, saturate, compare
    logic                                 vh_reg;
    logic [SUW-1:0]                       sum_h;
    logic [QW-1:0]                        dsq_h_reg;
    logic [QW-1:0]                        dsq_h_next;
    logic                                 hit_h_reg;
    logic signed [COORD_BITS-1:0]         near_h_reg [N];
    logic signed [COORD_BITS-1:0]         near_h_next [N];
    logic signed [XW-1:0]                 near_x [N];

    logic en_f, en_g, en_h;

    assign en_h     = !vh_reg || out_ready;
    assign en_g     = !vg_reg || en_h;
    assign en_f     = !vf_reg || en_g;
    assign in_ready = en_f;

    always_comb begin
        big_f_next = 1'b0;
        for (int k = 0; k < N; k++) begin
            d_f[k]        = EW'(in_p[k]) - EW'(in_near[k]);
            mag_f[k]      = d_f[k][EW-1] ? EW'(-d_f[k]) : EW'(d_f[k]);
            mag_f_next[k] = mag_f[k][MB-1:0];
            if (mag_f[k][EW-1:MB] != '0) big_f_next = 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            sq_g_next[k] = QW'(mag_f_reg[k]) * QW'(mag_f_reg[k]);
        end
    end

    always_comb begin
        sum_h = SUW'(sq_g_reg[0]) + SUW'(sq_g_reg[1]) + SUW'(sq_g_reg[2]);
        if (big_g_reg || sum_h > SUW'(sobb_pkg::DSQ_MAX)) begin
            dsq_h_next = sobb_pkg::DSQ_MAX;
        end else begin
            dsq_h_next = sum_h[QW-1:0];
        end
        for (int k = 0; k < N; k++) begin
            near_x[k] = XW'(near_g_reg[k]);
            if (near_x[k] > SAT_HI) begin
                near_h_next[k] = COORD_BITS'(SAT_HI);
            end else if (near_x[k] < SAT_LO) begin
                near_h_next[k] = COORD_BITS'(SAT_LO);
            end else begin
                near_h_next[k] = COORD_BITS'(near_x[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end else begin
            if (en_f) vf_reg <= in_valid;
            if (en_g) vg_reg <= vf_reg;
            if (en_h) vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f) begin
            mag_f_reg  <= mag_f_next;
            big_f_reg  <= big_f_next;
            near_f_reg <= in_near;
            r_f_reg    <= in_radius;
        end
        if (en_g) begin
            sq_g_reg   <= sq_g_next;
            rsq_g_reg  <= RW'(r_f_reg) * RW'(r_f_reg);
            big_g_reg  <= big_f_reg;
            near_g_reg <= near_f_reg;
        end
        if (en_h) begin
            dsq_h_reg  <= dsq_h_next;
            hit_h_reg  <= dsq_h_next < QW'(rsq_g_reg);
            near_h_reg <= near_h_next;
        end
    end

    assign out_valid = vh_reg;
    assign out_hit   = hit_h_reg;
    assign out_near  = near_h_reg;
    assign out_dsq   = dsq_h_reg;

endmodule

FILE: rtl/core/sobb_checker.sv
// ----------------------------------------------------------------------------
// Sphere/OBB overlap port checker
// Port-level assertions on result handshake and result consistency.
// ----------------------------------------------------------------------------
`include "sphere_obb_overlap_test_core_macros.svh"

module sobb_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_hit,
    input logic [COORD_BITS-1:0]         m_near_x,
    input logic [sobb_pkg::DSQ_BITS-1:0] m_distance_sq
);

    // stalled result stays put
    `SOBB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `SOBB_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_distance_sq) && $stable(m_hit) && $stable(m_near_x))
    // input side only blocks when the output transfer is blocked
    `SOBB_ASSERT_IMPLY(a_ready_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready)
    // radius squared stays below 2^30, so a hit needs a small distance
    `SOBB_ASSERT_IMPLY(a_hit_range, aclk, aresetn, m_valid && m_hit, m_distance_sq[sobb_pkg::DSQ_BITS-1:30] == '0)

endmodule

bind sphere_obb_overlap_test_core sobb_checker #(.COORD_BITS(COORD_BITS)) u_sobb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hit         (m_hit),
    .m_near_x      (m_near_x),
    .m_distance_sq (m_distance_sq)
);
